FILE: rtl/wis_pkg.sv
package wis_pkg;

    // Width of a cumulative sum, a sample and the running total.
    localparam int SUM_W = 24;
    // Width of the weight port.
    localparam int WEIGHT_W = 16;
    // Width of the index port.
    localparam int INDEX_W = 8;

    localparam int DEPTH_DEF = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    // Entries in the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DRAW   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ABOVE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REC_WRITE = 1'b0,
        REC_DRAW  = 1'b1
    } rec_kind_t;

    typedef enum logic [1:0] {
        BS_IDLE   = 2'd0,
        BS_SEARCH = 2'd1,
        BS_RESULT = 2'd2
    } back_state_t;

endpackage

FILE: rtl/wis_queue.sv
module wis_queue #(
    parameter int W = 8,
    parameter int QDEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    logic [W-1:0] slot_reg [QDEPTH];
    logic [PW:0]  wr_ptr_reg;
    logic [PW:0]  wr_ptr_next;
    logic [PW:0]  rd_ptr_reg;
    logic [PW:0]  rd_ptr_next;
    logic         do_wr;
    logic         do_rd;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]) &&
                   (wr_ptr_reg[PW] != rd_ptr_reg[PW]);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + (PW+1)'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg[PW-1:0]] <= wr_data;
        end
    end

endmodule

FILE: rtl/wis_front.sv
module wis_front #(
    parameter int DEPTH = wis_pkg::DEPTH_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF,
    parameter int REC_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   cmd,
    input  logic [wis_pkg::WEIGHT_W-1:0] weight,
    input  logic [wis_pkg::SUM_W-1:0]    sample,
    output logic                         q_push,
    output logic [REC_W-1:0]             q_data,
    input  logic                         q_full
);
    import wis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WB_USED = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam logic [WEIGHT_W-1:0] WMASK = WEIGHT_W'((33'd1 << WB_USED) - 33'd1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    logic             accept;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic             room;
    status_t          draw_status;

    assign accept   = push && !q_full;
    assign full     = q_full;
    assign room     = (count_reg < CW'(DEPTH));
    assign sum_wide = {1'b0, total_reg} + (SUM_W+1)'(weight & WMASK);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb
    begin
        if (count_reg == '0)
        begin
            draw_status = ST_EMPTY;
        end
        else if (sample > total_reg)
        begin
            draw_status = ST_ABOVE;
        end
        else
        begin
            draw_status = ST_OK;
        end
    end

    // Appends and draws go to the back end in order; the table itself
    // lives there, so a draw always sees every earlier append.
    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        q_push     = 1'b0;
        q_data     = {REC_WRITE, ST_OK, count_reg, sum_sat, sample};
        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_CLEAR:
                begin
                    count_next = '0;
                    total_next = '0;
                end
                CMD_APPEND:
                begin
                    if (room)
                    begin
                        count_next = count_reg + CW'(1);
                        total_next = sum_sat;
                        q_push     = 1'b1;
                    end
                end
                CMD_DRAW:
                begin
                    q_push = 1'b1;
                    q_data = {REC_DRAW, draw_status, count_reg, total_reg, sample};
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

endmodule

FILE: rtl/wis_back.sv
module wis_back #(
    parameter int DEPTH = wis_pkg::DEPTH_DEF,
    parameter int REC_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [REC_W-1:0]            q_data,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [wis_pkg::INDEX_W-1:0] index,
    output logic [1:0]                  status,
    output logic [wis_pkg::SUM_W-1:0]   weight_sum
);
    import wis_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [AW-1:0]    lo_reg;
    logic [AW-1:0]    lo_next;
    logic [AW-1:0]    hi_reg;
    logic [AW-1:0]    hi_next;
    logic [AW-1:0]    mid_reg;
    logic [AW-1:0]    mid_next;
    logic [SUM_W-1:0] sample_reg;
    logic [SUM_W-1:0] sample_next;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    status_t          status_reg;
    status_t          status_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [1:0]          out_status_reg;
    logic [SUM_W-1:0]    out_total_reg;

    rec_kind_t        rec_kind;
    status_t          rec_status;
    logic [CW-1:0]    rec_count;
    logic [SUM_W-1:0] rec_total;
    logic [SUM_W-1:0] rec_sample;
    logic [AW-1:0]    rec_last;

    logic             ge;
    logic [AW-1:0]    lo_step;
    logic [AW-1:0]    hi_step;
    logic [AW:0]      mid_sum;
    logic             out_free;
    logic             mem_we;
    logic [AW-1:0]    rd_addr;
    logic             load_out;
    logic [AW+INDEX_W-1:0] pos_ext;

    assign rec_kind   = rec_kind_t'(q_data[REC_W-1]);
    assign rec_status = status_t'(q_data[REC_W-2 -: 2]);
    assign rec_count  = q_data[2*SUM_W +: CW];
    assign rec_total  = q_data[SUM_W +: SUM_W];
    assign rec_sample = q_data[0 +: SUM_W];
    assign rec_last   = AW'(rec_count - CW'(1));

    // One search step: the entry at mid was read in the previous cycle.
    assign ge      = (sample_reg >= rd_data_reg);
    assign lo_step = ge ? (mid_reg + AW'(1)) : lo_reg;
    assign hi_step = ge ? hi_reg : mid_reg;
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        sample_next = sample_reg;
        total_next  = total_reg;
        status_next = status_reg;
        mid_sum     = '0;
        case (state_reg)
            BS_IDLE:
            begin
                if (!q_empty && rec_kind == REC_DRAW)
                begin
                    sample_next = rec_sample;
                    total_next  = rec_total;
                    status_next = rec_status;
                    lo_next     = '0;
                    hi_next     = rec_last;
                    mid_sum     = {1'b0, rec_last};
                    mid_next    = mid_sum[AW:1];
                    if (rec_status != ST_OK || rec_last == '0)
                    begin
                        state_next = BS_RESULT;
                    end
                    else
                    begin
                        state_next = BS_SEARCH;
                    end
                end
            end
            BS_SEARCH:
            begin
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
                mid_next = mid_sum[AW:1];
                if (lo_step == hi_step)
                begin
                    state_next = BS_RESULT;
                end
            end
            BS_RESULT:
            begin
                if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        load_out = 1'b0;
        rd_addr  = mid_next;
        case (state_reg)
            BS_IDLE:
            begin
                q_pop  = !q_empty;
                mem_we = !q_empty && rec_kind == REC_WRITE;
            end
            BS_SEARCH:
            begin
                q_pop = 1'b0;
            end
            BS_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pos_ext = {{INDEX_W{1'b0}}, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        sample_reg <= sample_next;
        total_reg  <= total_next;
        status_reg <= status_next;
        if (load_out)
        begin
            out_index_reg  <= (status_reg == ST_OK) ? pos_ext[INDEX_W-1:0] : '0;
            out_status_reg <= status_reg;
            out_total_reg  <= total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[rec_count[AW-1:0]] <= rec_total;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign empty      = !out_valid_reg;
    assign index      = out_index_reg;
    assign status     = out_status_reg;
    assign weight_sum = out_total_reg;

endmodule

FILE: rtl/weighted_index_sampler.sv
// A clear ends in the front end with no result; an append is queued and the back end writes
// it to the table. With the back end idle a draw is popped, searched and its result parked
// in the output register; an error status or a single entry table skips the search. The
// back end finishes one draw before it pops the next record, takes one binary search step
// per cycle through the single read port of the table memory and holds a result until the
// output register is free. Reset: rst_n clears the table count, the running total and the
// queue; table contents are not cleared, since only entries below the count are searched.
module weighted_index_sampler #(
    parameter int DEPTH = wis_pkg::DEPTH_DEF,
    parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   cmd,
    input  logic [wis_pkg::WEIGHT_W-1:0] weight,
    input  logic [wis_pkg::SUM_W-1:0]    sample,
    output logic                         empty,
    input  logic                         pop,
    output logic [wis_pkg::INDEX_W-1:0]  index,
    output logic [1:0]                   status,
    output logic [wis_pkg::SUM_W-1:0]    weight_sum
);
    import wis_pkg::*;

    // A queue record carries the kind, the draw status, the entry count, a sum and the sample.
    // For an append the count is the table address and the sum the new cumulative value;
    // for a draw they are the count and running total as they stood when the draw arrived.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int REC_W = 1 + 2 + CW + 2 * SUM_W;

    logic             q_push;
    logic [REC_W-1:0] q_wdata;
    logic             q_full;
    logic             q_pop;
    logic [REC_W-1:0] q_rdata;
    logic             q_empty;

    // The front end owns the running total and the entry count, so it can classify each
    // item at once: clears and ignored commands end here, appends and draws are queued.
    wis_front #(
        .DEPTH       (DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS),
        .REC_W       (REC_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .weight (weight),
        .sample (sample),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    // The short queue lets the front keep taking items while the back end searches.
    wis_queue #(
        .W      (REC_W),
        .QDEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // The back end writes the cumulative table and runs the binary search for draws, one
    // memory read and compare per cycle, then parks the result in an output register.
    wis_back #(
        .DEPTH (DEPTH),
        .REC_W (REC_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .index      (index),
        .status     (status),
        .weight_sum (weight_sum)
    );

endmodule
